### rtl/plil_pkg.sv
package plil_pkg;

  // Field widths fixed by the item and register formats
  localparam int INDEX_W  = 6;
  localparam int DIST_W   = 15;
  localparam int STEP_W   = 16;
  localparam int POINTS_W = 7;
  localparam int TIME_W   = 18;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int TABLE_POINTS_DEFAULT = 64;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [STEP_W-1:0]   GRID_STEP_RESET     = 16'd700;
  localparam logic [POINTS_W-1:0] POINTS_IN_USE_RESET = 7'd50;

  typedef enum logic {
    ITEM_LOAD    = 1'b0,
    ITEM_CONVERT = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t                 kind;
    logic [INDEX_W-1:0]         index;
    logic signed [DIST_W-1:0]   distance;
  } queue_entry_t;

  typedef struct packed {
    logic [STEP_W-1:0]   grid_step;
    logic [POINTS_W-1:0] points_in_use;
  } cfg_t;

endpackage

### rtl/plil_ram.sv
module plil_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/plil_queue.sv
module plil_queue #(
  parameter int DEPTH = plil_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  plil_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output plil_pkg::queue_entry_t head,
  output logic                   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  plil_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    ptr_advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_advance(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

endmodule

### rtl/plil_front.sv
module plil_front #(
  parameter int TABLE_POINTS = plil_pkg::TABLE_POINTS_DEFAULT
) (
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 mode,
  input  logic [plil_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [plil_pkg::DIST_W-1:0]   entry_distance,
  input  logic signed [plil_pkg::DIST_W-1:0]   query_distance,
  input  logic                                 queue_full,
  output logic                                 push,
  output plil_pkg::queue_entry_t               push_entry
);

  logic accept;
  logic in_range;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;

  // Drop loads aimed past the end of the table
  assign in_range = (int'(entry_index) < TABLE_POINTS);
  assign push     = accept && (mode || in_range);

  assign push_entry.kind     = mode ? plil_pkg::ITEM_CONVERT : plil_pkg::ITEM_LOAD;
  assign push_entry.index    = entry_index;
  assign push_entry.distance = mode ? query_distance : entry_distance;

endmodule

### rtl/plil_back.sv
module plil_back #(
  parameter int TABLE_POINTS = plil_pkg::TABLE_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  plil_pkg::cfg_t                         cfg,
  input  logic                                   q_not_empty,
  input  plil_pkg::queue_entry_t                 q_head,
  output logic                                   q_pop,
  output logic                                   ram_we,
  output logic [$clog2(TABLE_POINTS)-1:0]        ram_waddr,
  output logic [plil_pkg::DIST_W-1:0]            ram_wdata,
  output logic [$clog2(TABLE_POINTS)-1:0]        ram_raddr_a,
  output logic [$clog2(TABLE_POINTS)-1:0]        ram_raddr_b,
  input  logic [plil_pkg::DIST_W-1:0]            ram_rdata_a,
  input  logic [plil_pkg::DIST_W-1:0]            ram_rdata_b,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [plil_pkg::TIME_W-1:0]     drift_time,
  output logic [plil_pkg::STATUS_W-1:0]          status
);

  localparam int IDX_W     = $clog2(TABLE_POINTS);
  localparam int CNT_W     = $clog2(TABLE_POINTS + 1);
  localparam int CMP_W     = (CNT_W > plil_pkg::POINTS_W) ? CNT_W : plil_pkg::POINTS_W;
  localparam int DIST_W    = plil_pkg::DIST_W;
  localparam int STEP_W    = plil_pkg::STEP_W;
  localparam int TIME_W    = plil_pkg::TIME_W;
  localparam int DY_W      = DIST_W + 1;
  localparam int DEN_W     = DIST_W;
  localparam int SEGSTEP_W = IDX_W + STEP_W;
  localparam int PROD1_W   = SEGSTEP_W + 1 + DY_W;
  localparam int PROD2_W   = STEP_W + 1 + DY_W;
  localparam int NUM_W     = IDX_W + 2 * STEP_W + 2;
  localparam int DIV_STEPS = TIME_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int TIME_MAX_INT = 2 ** (TIME_W - 1) - 1;

  localparam logic [plil_pkg::STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [plil_pkg::STATUS_W-1:0] STATUS_FLAT = 2'd1;
  localparam logic [plil_pkg::STATUS_W-1:0] STATUS_SAT  = 2'd2;

  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [TIME_W-1:0]        NEG_MAG_LIMIT = {1'b1, {(TIME_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_ENDS, S_SCAN, S_FETCH, S_DIFF, S_MUL, S_SUM,
    S_ABS, S_DIVINIT, S_DIV, S_FIX, S_OUT
  } state_t;

  state_t                     state;
  logic signed [DIST_W-1:0]   qdist;
  logic [IDX_W-1:0]           seg;
  logic [IDX_W-1:0]           idx;
  logic signed [DIST_W-1:0]   d0;
  logic signed [DIST_W-1:0]   d1;
  logic signed [DY_W-1:0]     dy;
  logic signed [DY_W-1:0]     qd;
  logic [SEGSTEP_W-1:0]       segstep;
  logic signed [PROD1_W-1:0]  prod1;
  logic signed [PROD2_W-1:0]  prod2;
  logic signed [NUM_W-1:0]    num;
  logic [NUM_W-1:0]           num_mag;
  logic                       neg;
  logic [DEN_W-1:0]           den;
  logic [DEN_W-1:0]           rem;
  logic [TIME_W-1:0]          quo;
  logic [DCNT_W-1:0]          dcnt;
  logic signed [TIME_W-1:0]   pend_time;
  logic [plil_pkg::STATUS_W-1:0] pend_status;

  logic [CMP_W-1:0]           pts_wide;
  logic [CNT_W-1:0]           n_pts;
  logic [IDX_W-1:0]           last_idx;
  logic [IDX_W-1:0]           final_seg;
  logic [IDX_W-1:0]           scan_end;
  logic signed [DIST_W-1:0]   rd_a;
  logic signed [DIST_W-1:0]   rd_b;
  logic                       below_first;
  logic                       at_or_above_last;
  logic                       scan_hit;
  logic [DEN_W:0]             div_trial;
  logic                       div_ge;

  // Clamp the point count into the table
  assign pts_wide = CMP_W'(cfg.points_in_use);

  always_comb begin
    if (pts_wide < CMP_W'(2)) begin
      n_pts = CNT_W'(2);
    end else if (pts_wide > CMP_W'(TABLE_POINTS)) begin
      n_pts = CNT_W'(TABLE_POINTS);
    end else begin
      n_pts = CNT_W'(pts_wide);
    end
  end

  assign last_idx  = IDX_W'(n_pts - CNT_W'(1));
  assign final_seg = IDX_W'(n_pts - CNT_W'(2));
  assign scan_end  = IDX_W'(n_pts - CNT_W'(3));

  assign rd_a = ram_rdata_a;
  assign rd_b = ram_rdata_b;

  assign below_first      = (qdist < rd_a);
  assign at_or_above_last = (qdist >= rd_b);
  assign scan_hit         = (rd_a <= qdist) && (qdist < rd_b);

  assign div_trial = {rem, quo[TIME_W-1]};
  assign div_ge    = (div_trial >= {1'b0, den});

  assign q_pop     = (state == S_IDLE) && q_not_empty;
  assign ram_we    = q_pop && (q_head.kind == plil_pkg::ITEM_LOAD);
  assign ram_waddr = IDX_W'(q_head.index);
  assign ram_wdata = q_head.distance;

  // Read addresses; the table returns the data in the cycle after
  always_comb begin
    ram_raddr_a = '0;
    ram_raddr_b = last_idx;
    unique case (state)
      S_ENDS: begin
        if (!below_first && at_or_above_last) begin
          ram_raddr_a = final_seg;
          ram_raddr_b = last_idx;
        end else begin
          ram_raddr_a = '0;
          ram_raddr_b = IDX_W'(1);
        end
      end
      S_SCAN: begin
        if (!scan_hit && (idx == scan_end)) begin
          ram_raddr_a = final_seg;
          ram_raddr_b = last_idx;
        end else begin
          ram_raddr_a = idx + IDX_W'(1);
          ram_raddr_b = idx + IDX_W'(2);
        end
      end
      default: begin
        ram_raddr_a = '0;
        ram_raddr_b = last_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop && (q_head.kind == plil_pkg::ITEM_CONVERT)) begin
            qdist <= q_head.distance;
            state <= S_ENDS;
          end
        end
        S_ENDS: begin
          if (below_first) begin
            seg   <= '0;
            state <= S_FETCH;
          end else if (at_or_above_last) begin
            seg   <= final_seg;
            state <= S_FETCH;
          end else if (n_pts == CNT_W'(2)) begin
            seg   <= '0;
            state <= S_FETCH;
          end else begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            seg   <= idx;
            d0    <= rd_a;
            d1    <= rd_b;
            state <= S_DIFF;
          end else if (idx == scan_end) begin
            seg   <= final_seg;
            state <= S_FETCH;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_FETCH: begin
          d0    <= rd_a;
          d1    <= rd_b;
          state <= S_DIFF;
        end
        S_DIFF: begin
          dy      <= DY_W'(d1) - DY_W'(d0);
          qd      <= DY_W'(qdist) - DY_W'(d0);
          segstep <= SEGSTEP_W'(seg) * SEGSTEP_W'(cfg.grid_step);
          state   <= S_MUL;
        end
        S_MUL: begin
          prod1 <= $signed({1'b0, segstep}) * dy;
          prod2 <= $signed({1'b0, cfg.grid_step}) * qd;
          state <= S_SUM;
        end
        S_SUM: begin
          if (dy == '0) begin
            if (int'(segstep) > TIME_MAX_INT) begin
              pend_time   <= TIME_MAX;
              pend_status <= STATUS_SAT;
            end else begin
              pend_time   <= $signed(TIME_W'(segstep));
              pend_status <= STATUS_FLAT;
            end
            state <= S_OUT;
          end else begin
            num   <= NUM_W'(prod1) + NUM_W'(prod2);
            state <= S_ABS;
          end
        end
        S_ABS: begin
          num_mag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
          den     <= dy[DY_W-1] ? DEN_W'(-dy) : DEN_W'(dy);
          neg     <= num[NUM_W-1] ^ dy[DY_W-1];
          state   <= S_DIVINIT;
        end
        S_DIVINIT: begin
          // Quotient of 2^TIME_W or more: saturate at once
          if ((num_mag >> DIV_STEPS) >= NUM_W'(den)) begin
            pend_time   <= neg ? TIME_MIN : TIME_MAX;
            pend_status <= STATUS_SAT;
            state       <= S_OUT;
          end else begin
            rem   <= DEN_W'(num_mag >> DIV_STEPS);
            quo   <= num_mag[TIME_W-1:0];
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= DEN_W'(div_trial - {1'b0, den});
          end else begin
            rem <= DEN_W'(div_trial);
          end
          quo  <= {quo[TIME_W-2:0], div_ge};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (!neg) begin
            if (quo[TIME_W-1]) begin
              pend_time   <= TIME_MAX;
              pend_status <= STATUS_SAT;
            end else begin
              pend_time   <= $signed(quo);
              pend_status <= STATUS_OK;
            end
          end else begin
            if (quo > NEG_MAG_LIMIT) begin
              pend_time   <= TIME_MIN;
              pend_status <= STATUS_SAT;
            end else begin
              pend_time   <= $signed(TIME_W'(0) - quo);
              pend_status <= STATUS_OK;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            drift_time   <= pend_time;
            status       <= pend_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_below_den : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_write_only_idle : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("table written outside idle");

  a_result_from_out : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside output state");

endmodule

### rtl/piecewise_linear_inverse_lookup_core.sv
// Drift distance to drift time converter. A load transfer (mode 0) writes the curve distance
// at grid point entry_index, whose time is entry_index * grid_step; loads aimed past the table
// are dropped and give no result. A convert transfer (mode 1) gives exactly one result: the
// segment holding query_distance is found, the time is interpolated linearly within it and
// truncated toward zero. Queries below the first point extrapolate with segment 0, queries at
// or above the last point in use with the final segment. A flat segment returns its start
// time with status 1; a time outside the 18-bit range is clamped with status 2. Only
// table entries that have been loaded may be touched by a conversion. Items pass through a
// two-entry queue, so the input keeps taking transfers while a conversion runs or a result
// waits, until the queue is full. A load is written to the table as it leaves the queue.
// In a conversion the segment search reads one pair of table entries per cycle from the
// dual-read table RAM and walks the segments in order, and the division runs one quotient
// bit per cycle; a flat segment skips the division. Write configuration registers only
// while the block is idle.
module piecewise_linear_inverse_lookup_core #(
  parameter int TABLE_POINTS = plil_pkg::TABLE_POINTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [plil_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [plil_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [plil_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // input items
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   mode,
  input  logic [plil_pkg::INDEX_W-1:0]           entry_index,
  input  logic signed [plil_pkg::DIST_W-1:0]     entry_distance,
  input  logic signed [plil_pkg::DIST_W-1:0]     query_distance,
  // results
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [plil_pkg::TIME_W-1:0]     drift_time,
  output logic [plil_pkg::STATUS_W-1:0]          status
);

  localparam int IDX_W = $clog2(TABLE_POINTS);

  // Register index sits in address bit 2 (byte address 4 * index)
  localparam logic REG_GRID_STEP     = 1'b0;
  localparam logic REG_POINTS_IN_USE = 1'b1;

  logic [plil_pkg::STEP_W-1:0]   grid_step;
  logic [plil_pkg::POINTS_W-1:0] points_in_use;
  logic                          cfg_write;
  plil_pkg::cfg_t                cfg;

  logic                          queue_full;
  logic                          queue_push;
  plil_pkg::queue_entry_t        queue_in;
  logic                          queue_pop;
  plil_pkg::queue_entry_t        queue_head;
  logic                          queue_not_empty;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [plil_pkg::DIST_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]              ram_raddr_a;
  logic [IDX_W-1:0]              ram_raddr_b;
  logic [plil_pkg::DIST_W-1:0]   ram_rdata_a;
  logic [plil_pkg::DIST_W-1:0]   ram_rdata_b;

  // Configuration registers: pready held high, write on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_step     <= plil_pkg::GRID_STEP_RESET;
      points_in_use <= plil_pkg::POINTS_IN_USE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_GRID_STEP:     grid_step     <= pwdata[plil_pkg::STEP_W-1:0];
        REG_POINTS_IN_USE: points_in_use <= pwdata[plil_pkg::POINTS_W-1:0];
        default:           grid_step     <= grid_step;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_STEP:     prdata = plil_pkg::APB_DATA_W'(grid_step);
      REG_POINTS_IN_USE: prdata = plil_pkg::APB_DATA_W'(points_in_use);
      default:           prdata = '0;
    endcase
  end

  assign cfg.grid_step     = grid_step;
  assign cfg.points_in_use = points_in_use;

  // Front: take transfers, classify, drop stray loads
  plil_front #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_front (
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .query_distance (query_distance),
    .queue_full     (queue_full),
    .push           (queue_push),
    .push_entry     (queue_in)
  );

  // Hold items between front and back so each side stalls on its own
  plil_queue #(
    .DEPTH (plil_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (queue_push),
    .push_entry (queue_in),
    .full       (queue_full),
    .pop        (queue_pop),
    .head       (queue_head),
    .not_empty  (queue_not_empty)
  );

  // Back: table writes, segment search, interpolation and division
  plil_back #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (queue_not_empty),
    .q_head       (queue_head),
    .q_pop        (queue_pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr_a  (ram_raddr_a),
    .ram_raddr_b  (ram_raddr_b),
    .ram_rdata_a  (ram_rdata_a),
    .ram_rdata_b  (ram_rdata_b),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drift_time   (drift_time),
    .status       (status)
  );

  // Curve table: one write port, two registered read ports
  plil_ram #(
    .WIDTH (plil_pkg::DIST_W),
    .DEPTH (TABLE_POINTS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

endmodule

### tb/piecewise_linear_inverse_lookup_core_test.sv
`timescale 1ns / 100ps

module piecewise_linear_inverse_lookup_core_test;
  import plil_pkg::*;

  localparam int CLOCK_PERIOD     = 12;
  localparam int RESET_CYCLES     = 12;
  localparam int ITEM_TARGET      = 1550;
  // Leave room for the slowest conversion and for queued loads behind it.
  localparam int DRAIN_CYCLES     = 128;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int POINTS           = TABLE_POINTS_DEFAULT;

  localparam int DIST_MIN = -16384;
  localparam int DIST_MAX = 16383;
  localparam longint TIME_MAX = 131071;
  localparam longint TIME_MIN = -131072;

  // Register indexes; each register sits at byte address 4 * index
  localparam int REG_GRID_STEP     = 0;
  localparam int REG_POINTS_IN_USE = 1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FLAT      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

  typedef struct {
    logic signed [TIME_W-1:0] drift_time;
    logic [STATUS_W-1:0]      status;
  } drift_result_t;

  typedef enum {ROW_CONFIG, ROW_LOAD, ROW_CONVERT} row_op_t;

  // arg: register index or grid point; value: register value, load distance or query
  typedef struct {
    row_op_t             op;
    int                  arg;
    int                  value;
    bit                  typed;
    int                  exp_time;
    logic [STATUS_W-1:0] exp_status;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  // Directed opening. Four grid points in use, so only entries 0..3 are ever read;
  // entry 63 is loaded to exercise the top index but stays outside the curve.
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_CONFIG,  REG_GRID_STEP,     100,    0, 0,       STATUS_OK},
    '{ROW_CONFIG,  REG_POINTS_IN_USE, 4,      0, 0,       STATUS_OK},
    '{ROW_LOAD,    0,                 -16384, 0, 0,       STATUS_OK},
    '{ROW_LOAD,    1,                 0,      0, 0,       STATUS_OK},
    '{ROW_LOAD,    2,                 16383,  0, 0,       STATUS_OK},
    '{ROW_LOAD,    3,                 16383,  0, 0,       STATUS_OK},
    '{ROW_LOAD,    63,                5,      0, 0,       STATUS_OK},
    // query on the first point: start of segment 0
    '{ROW_CONVERT, 0,                 -16384, 1, 0,       STATUS_OK},
    // query at the last point lands on a flat final segment: its start time
    '{ROW_CONVERT, 0,                 16383,  1, 200,     STATUS_FLAT},
    '{ROW_CONVERT, 0,                 0,      1, 100,     STATUS_OK},
    '{ROW_CONVERT, 0,                 8192,   0, 0,       STATUS_OK},
    // truncation toward zero just below a grid point
    '{ROW_CONVERT, 0,                 -1,     0, 0,       STATUS_OK},
    '{ROW_CONFIG,  REG_GRID_STEP,     65535,  0, 0,       STATUS_OK},
    '{ROW_CONVERT, 0,                 16383,  1, 131070,  STATUS_FLAT},
    '{ROW_LOAD,    2,                 1,      0, 0,       STATUS_OK},
    // steep final segment at the largest step: clamp high
    '{ROW_CONVERT, 0,                 16383,  1, 131071,  STATUS_SATURATED},
    '{ROW_LOAD,    0,                 -1,     0, 0,       STATUS_OK},
    // far below the first point: extrapolate segment 0 and clamp low
    '{ROW_CONVERT, 0,                 -16384, 1, -131072, STATUS_SATURATED},
    '{ROW_CONVERT, 0,                 0,      0, 0,       STATUS_OK},
    '{ROW_CONFIG,  REG_GRID_STEP,     0,      0, 0,       STATUS_OK},
    // zero grid step: every time collapses to zero
    '{ROW_CONVERT, 0,                 8192,   1, 0,       STATUS_OK},
    '{ROW_CONVERT, 0,                 16383,  1, 0,       STATUS_OK},
    '{ROW_LOAD,    3,                 1,      0, 0,       STATUS_OK},
    '{ROW_CONVERT, 0,                 5,      1, 0,       STATUS_FLAT},
    // a count of two, the minimum, leaves one segment only
    '{ROW_CONFIG,  REG_POINTS_IN_USE, 2,      0, 0,       STATUS_OK},
    '{ROW_CONFIG,  REG_GRID_STEP,     700,    0, 0,       STATUS_OK},
    '{ROW_CONVERT, 0,                 -16384, 0, 0,       STATUS_OK},
    '{ROW_CONVERT, 0,                 -1,     1, 0,       STATUS_OK}
  };

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [APB_ADDR_W-1:0]        paddr;
  logic [APB_DATA_W-1:0]        pwdata;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;
  logic                         item_valid;
  logic                         item_stall;
  logic                         mode;
  logic [INDEX_W-1:0]           entry_index;
  logic signed [DIST_W-1:0]     entry_distance;
  logic signed [DIST_W-1:0]     query_distance;
  logic                         result_valid;
  logic                         result_stall;
  logic signed [TIME_W-1:0]     drift_time;
  logic [STATUS_W-1:0]          status;

  // Shadow copy of the block's curve and registers, updated on each accepted transfer
  logic signed [DIST_W-1:0] curve [POINTS];
  logic [STEP_W-1:0]        grid_cfg = GRID_STEP_RESET;
  logic [POINTS_W-1:0]      pts_cfg  = POINTS_IN_USE_RESET;

  drift_result_t pending_results [$];
  int failures      = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;

  piecewise_linear_inverse_lookup_core dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .query_distance (query_distance),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .drift_time     (drift_time),
    .status         (status)
  );

  initial begin
    clk = 1'b0;
    forever #(CLOCK_PERIOD / 2) clk = ~clk;
  end

  // Give up once the limit is reached; a hung handshake ends here.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Clamp the points count into the usable range of the table.
  function automatic int active_count();
    if (pts_cfg < 2) return 2;
    if (pts_cfg > POINTS) return POINTS;
    return pts_cfg;
  endfunction

  function automatic int clip_distance(input int v);
    if (v < DIST_MIN) return DIST_MIN;
    if (v > DIST_MAX) return DIST_MAX;
    return v;
  endfunction

  // Expected time for one query against the shadow curve, in exact 64-bit arithmetic.
  function automatic drift_result_t predict_drift(input logic signed [DIST_W-1:0] query);
    drift_result_t r;
    int            n, seg, i;
    longint        q, d0, d1, dy, stepv, t;
    n     = active_count();
    q     = query;
    stepv = grid_cfg;
    if (q < curve[0]) begin
      seg = 0;
    end else if (q >= curve[n-1]) begin
      seg = n - 2;
    end else begin
      // Walk downwards so the lowest matching segment wins; a non-monotonic
      // curve with no match falls back to the final segment.
      seg = n - 2;
      for (i = n - 3; i >= 0; i--) begin
        if (q >= curve[i] && q < curve[i+1]) seg = i;
      end
    end
    d0 = curve[seg];
    d1 = curve[seg+1];
    dy = d1 - d0;
    r.status = STATUS_OK;
    if (dy == 0) begin
      t = seg * stepv;
      r.status = STATUS_FLAT;
    end else begin
      t = (seg * stepv * dy + stepv * (q - d0)) / dy;
    end
    // Saturation overrides the flat flag.
    if (t > TIME_MAX) begin
      t = TIME_MAX;
      r.status = STATUS_SATURATED;
    end else if (t < TIME_MIN) begin
      t = TIME_MIN;
      r.status = STATUS_SATURATED;
    end
    r.drift_time = t[TIME_W-1:0];
    return r;
  endfunction

  // Offer one item, called at a falling edge and returning at one. Hold valid high
  // from one transfer to the next unless an idle cycle is drawn.
  task automatic offer(input item_kind_t kind, input logic [INDEX_W-1:0] index,
                       input logic signed [DIST_W-1:0] distance,
                       input logic signed [DIST_W-1:0] query,
                       input bit typed, input int typed_time,
                       input logic [STATUS_W-1:0] typed_status);
    drift_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid     = 1'b1;
    mode           = kind;
    entry_index    = index;
    entry_distance = distance;
    query_distance = query;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (kind == ITEM_LOAD) begin
      curve[index] = distance;
    end else if (typed) begin
      r.drift_time = typed_time;
      r.status     = typed_status;
      pending_results.push_back(r);
    end else begin
      pending_results.push_back(predict_drift(query));
    end
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding conversion has returned.
  task automatic pause_for_results();
    item_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Loads give no result, so allow a trailing load to clear the datapath too.
  task automatic settle_block();
    pause_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write one register with a setup and an access phase, then read it back.
  task automatic write_register(input int reg_index, input int value);
    logic [APB_DATA_W-1:0] readback, want;
    string                 name;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = reg_index * 4;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_index == REG_GRID_STEP) begin
      grid_cfg = value;
      want     = {{(APB_DATA_W-STEP_W){1'b0}}, grid_cfg};
      name     = "grid_step";
    end else begin
      pts_cfg = value;
      want    = {{(APB_DATA_W-POINTS_W){1'b0}}, pts_cfg};
      name    = "points_in_use";
    end
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, readback);
      failures++;
    end
  endtask

  // Result side: stall at random, and on request hold off for a long stretch so the
  // input queue fills up behind it.
  initial begin : result_sink
    int hold_served;
    hold_served  = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        result_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      result_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    drift_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no conversion outstanding: drift_time %0d status %0d",
               drift_time, status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (drift_time !== want.drift_time) begin
          $error("drift_time: expected %0d, actual %0d", want.drift_time, drift_time);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    int n, k, convs, pick, lo, hi, a, b, q, v, inc_max, g, p, phase_no;
    int plan [POINTS];
    bit noisy, flat_heavy;
    item_valid     = 1'b0;
    mode           = ITEM_LOAD;
    entry_index    = '0;
    entry_distance = '0;
    query_distance = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst            = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 26;
    stall_pct     = 63;

    // Walk the directed script
    foreach (script[r]) begin
      case (script[r].op)
        ROW_CONFIG: begin
          settle_block();
          write_register(script[r].arg, script[r].value);
        end
        ROW_LOAD: begin
          offer(ITEM_LOAD, script[r].arg, script[r].value, $urandom_range(32767),
                1'b0, 0, STATUS_OK);
        end
        default: begin
          offer(ITEM_CONVERT, $urandom_range(63), $urandom_range(32767), script[r].value,
                script[r].typed, script[r].exp_time, script[r].exp_status);
        end
      endcase
    end

    // Random phases: reconfigure, load a fresh curve over the points in use, then
    // run a burst of conversions with the odd stray load mixed in.
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        send_idle_pct = 26;
        stall_pct     = 63;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 63;
        stall_pct     = 26;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      settle_block();

      // Open with the register extremes, then draw settings at random
      if (phase_no == 0) begin
        g = 65535;
        p = 127;
      end else if (phase_no == 1) begin
        g = 1;
        p = 0;
      end else begin
        case ($urandom_range(9))
          0:       g = 0;
          1:       g = 1;
          2:       g = 65535;
          3:       g = $urandom_range(65535);
          default: g = $urandom_range(1, 1500);
        endcase
        case ($urandom_range(9))
          0:       p = 0;
          1:       p = 1;
          2:       p = 2;
          3:       p = 64;
          4:       p = 127;
          5:       p = $urandom_range(65, 126);
          default: p = $urandom_range(3, 63);
        endcase
      end
      write_register(REG_GRID_STEP, g);
      write_register(REG_POINTS_IN_USE, p);
      n = active_count();

      // Mostly rising curves, some with many flat steps, a few pure noise
      pick       = $urandom_range(9);
      noisy      = (pick >= 8);
      flat_heavy = (pick == 7);
      v          = -int'($urandom_range(16384));
      inc_max    = $urandom_range(1, 32767 / (n - 1));
      for (k = 0; k < n; k++) begin
        if (noisy) begin
          plan[k] = int'($urandom_range(32767)) + DIST_MIN;
        end else begin
          plan[k] = v;
          if ($urandom_range(9) >= (flat_heavy ? 5 : 1)) v = v + int'($urandom_range(1, inc_max));
          if (v > DIST_MAX) v = DIST_MAX;
        end
      end
      for (k = 0; k < n; k++) begin
        offer(ITEM_LOAD, k, plan[k], $urandom_range(32767), 1'b0, 0, STATUS_OK);
      end

      // Stop the result side for a long stretch while conversions keep coming
      if (phase_no == 2) hold_requests++;

      convs = $urandom_range(40, 70);
      for (k = 0; k < convs; k++) begin
        // Once, let the input run dry until every result is back
        if (phase_no == 4 && k == convs / 2) pause_for_results();
        if ($urandom_range(19) == 0) begin
          offer(ITEM_LOAD, $urandom_range(63), $urandom_range(32767), $urandom_range(32767),
                1'b0, 0, STATUS_OK);
        end else begin
          a    = curve[0];
          b    = curve[n-1];
          lo   = clip_distance((a < b ? a : b) - 64);
          hi   = clip_distance((a < b ? b : a) + 64);
          pick = $urandom_range(99);
          if (pick < 65) begin
            q = lo + int'($urandom_range(hi - lo));
          end else if (pick < 85) begin
            // On or either side of a grid point
            q = clip_distance(int'(curve[$urandom_range(n - 1)]) + int'($urandom_range(2)) - 1);
          end else begin
            q = int'($urandom_range(32767)) + DIST_MIN;
          end
          offer(ITEM_CONVERT, $urandom_range(63), $urandom_range(32767), q,
                1'b0, 0, STATUS_OK);
        end
      end
      phase_no++;
    end

    settle_block();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/plil_pkg.sv
rtl/plil_ram.sv
rtl/plil_queue.sv
rtl/plil_front.sv
rtl/plil_back.sv
rtl/piecewise_linear_inverse_lookup_core.sv
tb/piecewise_linear_inverse_lookup_core_test.sv
